@@ sv/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check an implication on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    `ASSERT_CLK(label, clk, rst_n, (pre) |-> (post), msg)

// check an implication in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    `ASSERT_CLK(label, clk, rst_n, (pre) |=> (post), msg)

`endif

@@ sv/sepd_pkg.sv @@
`default_nettype none

package sepd_pkg;

    localparam logic [7:0]  START_BYTE        = 8'h02;
    localparam logic [7:0]  END_BYTE          = 8'h03;
    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd100;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_CMD     = 4'd1,
        PH_DIR     = 4'd2,
        PH_ERR     = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CHECK   = 4'd7,
        PH_END     = 4'd8
    } phase_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  error_code;
        logic [7:0]  direction;
        logic [7:0]  command_code;
        logic [15:0] data_index;
        logic [7:0]  data_byte;
    } result_data_t;

    typedef struct packed {
        logic packet_ok;
        logic data_valid;
    } result_user_t;

endpackage

`default_nettype wire

@@ sv/stx_etx_packet_deframer.sv @@
// stx/etx packet deframer
// input stream: one request per cycle unless the output stalls; tuser says
// whether it is a received byte or a one millisecond tick, tdata carries the byte.
// frames are 0x02, command, direction, error, length lo, length hi, payload,
// xor checksum over command through payload, 0x03.
// output stream: exactly one request per input request. tuser flags a
// payload byte (with its index) or a good frame end; tdata also carries the
// header fields of the latest frame as held after that request.
// output valid is registered: it rises in the cycle after input accept.
// throughput: one request per cycle, set by the single result register; the
// parser state updates in the same cycle the request is accepted.
// when the receiver stalls the result register holds and the input takes a
// new request only once that result is taken.
// cfg_wen / cfg_wdata write the inter-byte gap timeout in ticks; a byte seen
// after a gap at or above it restarts the hunt for 0x02.
// reset: parser hunts for 0x02, header fields and counters clear, timeout
// returns to 100 ticks, output stream is empty.

`default_nettype none
`include "assert_macros.svh"

module stx_etx_packet_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    input  wire logic        s_axis_tuser,   // cmd

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // data_byte, data_index, command_code, direction, error_code, payload_length
    output      logic [63:0] m_axis_tdata,
    output      logic [1:0]  m_axis_tuser    // data_valid, packet_ok
);

    logic [15:0]       timeout_reg;
    sepd_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        csum_reg, csum_next;
    logic [7:0]        rx_csum_reg, rx_csum_next;
    logic [7:0]        command_reg, command_next;
    logic [7:0]        direction_reg, direction_next;
    logic [7:0]        error_reg, error_next;
    logic [15:0]       length_reg, length_next;
    logic [15:0]       position_reg, position_next;
    logic [15:0]       gap_reg, gap_next;

    logic                   out_valid_reg;
    sepd_pkg::result_data_t out_data_reg, out_data_next;
    sepd_pkg::result_user_t out_user_reg, out_user_next;

    logic             in_accept;
    sepd_pkg::phase_t phase_eff;
    logic [7:0]       b;
    logic [15:0]      length_full;
    logic [15:0]      position_inc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign length_full   = {b, length_reg[7:0]};
    assign position_inc  = position_reg + 16'd1;

    // parser next state
    always_comb
    begin
        phase_next     = phase_reg;
        csum_next      = csum_reg;
        rx_csum_next   = rx_csum_reg;
        command_next   = command_reg;
        direction_next = direction_reg;
        error_next     = error_reg;
        length_next    = length_reg;
        position_next  = position_reg;
        gap_next       = gap_reg;
        out_user_next  = '0;
        out_data_next  = '0;
        phase_eff      = (gap_reg >= timeout_reg) ? sepd_pkg::PH_START : phase_reg;

        if (s_axis_tuser == sepd_pkg::KIND_TICK)
        begin
            if (gap_reg < timeout_reg)
            begin
                gap_next = gap_reg + 16'd1;
            end
        end
        else
        begin
            gap_next = '0;
            case (phase_eff)
                sepd_pkg::PH_CMD:
                begin
                    command_next = b;
                    csum_next    = csum_reg ^ b;
                    phase_next   = sepd_pkg::PH_DIR;
                end
                sepd_pkg::PH_DIR:
                begin
                    direction_next = b;
                    csum_next      = csum_reg ^ b;
                    phase_next     = sepd_pkg::PH_ERR;
                end
                sepd_pkg::PH_ERR:
                begin
                    error_next = b;
                    csum_next  = csum_reg ^ b;
                    phase_next = sepd_pkg::PH_LEN_LO;
                end
                sepd_pkg::PH_LEN_LO:
                begin
                    length_next = {8'd0, b};
                    csum_next   = csum_reg ^ b;
                    phase_next  = sepd_pkg::PH_LEN_HI;
                end
                sepd_pkg::PH_LEN_HI:
                begin
                    length_next = length_full;
                    csum_next   = csum_reg ^ b;
                    if (length_full != 16'd0)
                    begin
                        position_next = '0;
                        phase_next    = sepd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = sepd_pkg::PH_CHECK;
                    end
                end
                sepd_pkg::PH_PAYLOAD:
                begin
                    out_user_next.data_valid = 1'b1;
                    out_data_next.data_byte  = b;
                    out_data_next.data_index = position_reg;
                    csum_next                = csum_reg ^ b;
                    position_next            = position_inc;
                    phase_next               = (position_inc == length_reg) ?
                                               sepd_pkg::PH_CHECK : sepd_pkg::PH_PAYLOAD;
                end
                sepd_pkg::PH_CHECK:
                begin
                    rx_csum_next = b;
                    phase_next   = sepd_pkg::PH_END;
                end
                sepd_pkg::PH_END:
                begin
                    out_user_next.packet_ok = (b == sepd_pkg::END_BYTE) &&
                                              (csum_reg == rx_csum_reg);
                    phase_next = sepd_pkg::PH_START;
                end
                default:
                begin
                    if (b == sepd_pkg::START_BYTE)
                    begin
                        csum_next  = '0;
                        phase_next = sepd_pkg::PH_CMD;
                    end
                    else
                    begin
                        phase_next = sepd_pkg::PH_START;
                    end
                end
            endcase
        end

        out_data_next.command_code   = command_next;
        out_data_next.direction      = direction_next;
        out_data_next.error_code     = error_next;
        out_data_next.payload_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= sepd_pkg::GAP_TIMEOUT_RESET;
            phase_reg     <= sepd_pkg::PH_START;
            csum_reg      <= '0;
            rx_csum_reg   <= '0;
            command_reg   <= '0;
            direction_reg <= '0;
            error_reg     <= '0;
            length_reg    <= '0;
            position_reg  <= '0;
            gap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (in_accept)
            begin
                phase_reg     <= phase_next;
                csum_reg      <= csum_next;
                rx_csum_reg   <= rx_csum_next;
                command_reg   <= command_next;
                direction_reg <= direction_next;
                error_reg     <= error_next;
                length_reg    <= length_next;
                position_reg  <= position_next;
                gap_reg       <= gap_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `ASSERT_CLK(a_flags_exclusive, clk, rst_n,
        !(m_axis_tvalid && out_user_reg.data_valid && out_user_reg.packet_ok),
        "payload byte and frame end flagged together")

    `ASSERT_IMPLY(a_index_in_range, clk, rst_n,
        m_axis_tvalid && out_user_reg.data_valid,
        out_data_reg.data_index < out_data_reg.payload_length,
        "payload index beyond frame length")

    `ASSERT_NEXT(a_end_returns_to_hunt, clk, rst_n,
        in_accept && (s_axis_tuser == sepd_pkg::KIND_BYTE) &&
            (phase_reg == sepd_pkg::PH_END) && (gap_reg < timeout_reg),
        phase_reg == sepd_pkg::PH_START,
        "parser did not return to hunting after end byte")

    `ASSERT_NEXT(a_stall_holds_result, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(out_user_reg) && $stable(out_data_reg),
        "stalled result changed")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;

    typedef struct packed {
        sepd_pkg::result_user_t user;
        sepd_pkg::result_data_t data;
    } deframe_out_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } rx_item_t;

    typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_CUT} frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // parser mirror
    sepd_pkg::phase_t hunt_phase = sepd_pkg::PH_START;
    logic [7:0]  csum_run   = '0;
    logic [7:0]  csum_rx    = '0;
    logic [7:0]  hdr_cmd    = '0;
    logic [7:0]  hdr_dir    = '0;
    logic [7:0]  hdr_err    = '0;
    logic [15:0] hdr_len    = '0;
    logic [15:0] pay_pos    = '0;
    logic [15:0] gap_count  = '0;
    logic [15:0] gap_limit  = sepd_pkg::GAP_TIMEOUT_RESET;

    rx_item_t     pending_items[$];
    deframe_out_t awaited_results[$];
    int unsigned  queued     = 0;
    int unsigned  mismatches = 0;
    int unsigned  phase_no   = 0;
    bit           calm       = 0;
    bit           in_taken   = 0;
    int unsigned  send_idle  = 0;
    int unsigned  recv_stall = 0;
    int unsigned  hold_left  = 0;
    bit           held_long  = 0;

    stx_etx_packet_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic deframe_out_t deframe_step(input logic kind, input logic [7:0] b);
        deframe_out_t r;
        r = '0;
        if (kind == sepd_pkg::KIND_TICK)
        begin
            if (gap_count < gap_limit)
                gap_count = gap_count + 16'd1;
        end
        else
        begin
            if (gap_count >= gap_limit)
                hunt_phase = sepd_pkg::PH_START;
            gap_count = '0;
            case (hunt_phase)
                sepd_pkg::PH_CMD:
                begin
                    hdr_cmd = b;
                    csum_run ^= b;
                    hunt_phase = sepd_pkg::PH_DIR;
                end
                sepd_pkg::PH_DIR:
                begin
                    hdr_dir = b;
                    csum_run ^= b;
                    hunt_phase = sepd_pkg::PH_ERR;
                end
                sepd_pkg::PH_ERR:
                begin
                    hdr_err = b;
                    csum_run ^= b;
                    hunt_phase = sepd_pkg::PH_LEN_LO;
                end
                sepd_pkg::PH_LEN_LO:
                begin
                    hdr_len = {8'h00, b};
                    csum_run ^= b;
                    hunt_phase = sepd_pkg::PH_LEN_HI;
                end
                sepd_pkg::PH_LEN_HI:
                begin
                    hdr_len = {b, hdr_len[7:0]};
                    csum_run ^= b;
                    if (hdr_len != 16'd0)
                    begin
                        pay_pos = '0;
                        hunt_phase = sepd_pkg::PH_PAYLOAD;
                    end
                    else
                        hunt_phase = sepd_pkg::PH_CHECK;
                end
                sepd_pkg::PH_PAYLOAD:
                begin
                    r.user.data_valid = 1'b1;
                    r.data.data_byte = b;
                    r.data.data_index = pay_pos;
                    csum_run ^= b;
                    pay_pos = pay_pos + 16'd1;
                    if (pay_pos == hdr_len)
                        hunt_phase = sepd_pkg::PH_CHECK;
                end
                sepd_pkg::PH_CHECK:
                begin
                    csum_rx = b;
                    hunt_phase = sepd_pkg::PH_END;
                end
                sepd_pkg::PH_END:
                begin
                    if (b == sepd_pkg::END_BYTE && csum_run == csum_rx)
                        r.user.packet_ok = 1'b1;
                    hunt_phase = sepd_pkg::PH_START;
                end
                default:
                begin
                    hunt_phase = sepd_pkg::PH_START;
                    if (b == sepd_pkg::START_BYTE)
                    begin
                        csum_run = '0;
                        hunt_phase = sepd_pkg::PH_CMD;
                    end
                end
            endcase
        end
        r.data.command_code = hdr_cmd;
        r.data.direction = hdr_dir;
        r.data.error_code = hdr_err;
        r.data.payload_length = hdr_len;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // driver
    always @(negedge clk)
    begin : drive_proc
        rx_item_t it;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (send_idle > 0)
            begin
                send_idle--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                send_idle = $urandom_range(1, 7) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= it.kind;
                s_axis_tdata <= it.value;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (phase_no == 1 && !held_long)
            begin
                held_long = 1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch_proc
        deframe_out_t want;
        sepd_pkg::result_data_t got_d;
        sepd_pkg::result_user_t got_u;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(deframe_step(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_d = m_axis_tdata;
                got_u = m_axis_tuser;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none actual %h %h", $time,
                             m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("data_valid", 16'(want.user.data_valid),
                                16'(got_u.data_valid));
                    check_field("packet_ok", 16'(want.user.packet_ok),
                                16'(got_u.packet_ok));
                    check_field("data_byte", 16'(want.data.data_byte),
                                16'(got_d.data_byte));
                    check_field("data_index", want.data.data_index, got_d.data_index);
                    check_field("command_code", 16'(want.data.command_code),
                                16'(got_d.command_code));
                    check_field("direction", 16'(want.data.direction),
                                16'(got_d.direction));
                    check_field("error_code", 16'(want.data.error_code),
                                16'(got_d.error_code));
                    check_field("payload_length", want.data.payload_length,
                                got_d.payload_length);
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] v);
        pending_items.push_back('{kind: sepd_pkg::KIND_BYTE, value: v});
        queued++;
    endtask

    task automatic add_ticks(input int unsigned n);
        repeat (n)
        begin
            pending_items.push_back('{kind: sepd_pkg::KIND_TICK,
                                      value: 8'($urandom_range(0, 255))});
            queued++;
        end
    endtask

    task automatic add_frame(input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
                             input logic [15:0] len, input frame_kind_t how);
        logic [7:0]  seq[$];
        logic [7:0]  sum;
        logic [7:0]  v;
        int unsigned body;
        int unsigned n;
        seq = '{sepd_pkg::START_BYTE, c, d, e, len[7:0], len[15:8]};
        sum = c ^ d ^ e ^ len[7:0] ^ len[15:8];
        body = (how == FRAME_CUT && len > 8) ? 8 : len;
        for (int i = 0; i < body; i++)
        begin
            v = 8'($urandom_range(0, 255));
            sum ^= v;
            seq.push_back(v);
        end
        if (how == FRAME_BAD_SUM)
            sum ^= 8'($urandom_range(1, 255));
        seq.push_back(sum);
        if (how == FRAME_BAD_END)
            seq.push_back(sepd_pkg::END_BYTE ^ 8'($urandom_range(1, 255)));
        else
            seq.push_back(sepd_pkg::END_BYTE);
        n = (how == FRAME_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int i = 0; i < n; i++)
        begin
            add_byte(seq[i]);
            // short pauses below the gap limit keep the frame alive
            if (gap_limit > 1 && $urandom_range(0, 7) == 0)
                add_ticks($urandom_range(1, gap_limit > 10 ? 10 : gap_limit - 1));
        end
        if (how == FRAME_CUT && gap_limit <= 300)
            add_ticks(gap_limit + $urandom_range(0, 2));
    endtask

    task automatic add_mix(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        logic [15:0] len;
        frame_kind_t how;
        stop_at = queued + n;
        while (queued < stop_at)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 12)
            begin
                if (pick < 6)
                    how = FRAME_GOOD;
                else if (pick < 8)
                    how = FRAME_BAD_SUM;
                else if (pick < 10)
                    how = FRAME_BAD_END;
                else
                    how = FRAME_CUT;
                if (how == FRAME_CUT)
                    len = 16'($urandom_range(0, 65535));
                else if ($urandom_range(0, 15) == 0)
                    len = 16'($urandom_range(16, 40));
                else
                    len = 16'($urandom_range(0, 5));
                add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), len, how);
            end
            else if (pick < 14)
            begin
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else if (pick == 14)
                add_ticks($urandom_range(1, 5));
            else if (gap_limit <= 300)
                add_ticks(gap_limit + $urandom_range(0, 2));
            else
                add_ticks($urandom_range(1, 5));
        end
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gap_timeout(input logic [15:0] v);
        settle();
        repeat (4) @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen <= 1'b0;
        gap_limit = v;
    endtask

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = sepd_pkg::KIND_BYTE;
        m_axis_tready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset timeout: good frame with extreme header bytes, empty frame with a bad end
        add_frame(8'hFF, 8'h00, 8'h80, 16'd2, FRAME_GOOD);
        add_frame(8'h00, 8'hFF, 8'h7F, 16'd0, FRAME_BAD_END);
        phase_no = 1;
        add_mix(130);

        // gap reached mid header restarts the hunt
        write_gap_timeout(16'd2);
        add_byte(sepd_pkg::START_BYTE);
        add_byte(8'h11);
        add_ticks(2);
        add_frame(8'h01, 8'hFE, 8'h40, 16'd1, FRAME_GOOD);
        add_mix(60);

        write_gap_timeout(16'd1);
        add_mix(60);

        write_gap_timeout(16'd0);
        add_mix(30);

        write_gap_timeout(16'($urandom_range(3, 40)));
        add_mix(100);

        // widest timeout, a long pause keeps the frame alive
        write_gap_timeout(16'hFFFF);
        add_byte(sepd_pkg::START_BYTE);
        add_byte(8'h11);
        add_ticks(40);
        add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'd2, FRAME_GOOD);
        add_mix(20);

        write_gap_timeout(sepd_pkg::GAP_TIMEOUT_RESET);
        calm = 1;
        add_mix(80);

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
